// ----- hdl/mddm_pkg.sv -----
// ----------------------------------------------------------------------------
// mddm_pkg
// Shared widths and register codes of the dead-band duty mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package mddm_pkg;

	// field widths
	localparam int IN_W  = 16;
	localparam int REG_W = 14;
	localparam int OUT_W = 14;

	// configuration register index
	typedef logic [0:0] cfg_idx_t;

	localparam cfg_idx_t REG_THRESHOLD = 1'b0;
	localparam cfg_idx_t REG_START     = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/motor_deadband_duty_mapper_core.sv -----
// ----------------------------------------------------------------------------
// motor_deadband_duty_mapper_core
// Maps a signed speed command onto two H-bridge PWM duties with dead-band
// compensation: clamp, threshold test, linear remap through a pipelined
// restoring divider, then steering to the forward or reverse channel.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  input    | in_valid / in_stall | speed_cmd (16b signed)
//  output   | out_valid/out_stall | duty_forward, duty_reverse (14b)
//  config   | cfg_we              | cfg_index (1b), cfg_data (14b)
//
//  one transaction per cycle sustained while out_stall is low; the divider
//  sets the pipeline depth, one quotient bit a stage
//  arst_n clears all stage valid bits and both registers
//  every stage holds while its successor is full and stalled; empty stages
//  fill, so input is stalled only when every stage holds a transaction
// ----------------------------------------------------------------------------
`default_nettype none

module motor_deadband_duty_mapper_core
	import mddm_pkg::*;
#(
	parameter int unsigned FULL_SCALE = 10000
) (
	input  wire                     clk,
	input  wire                     arst_n,
	// configuration
	input  wire                     cfg_we,
	input  wire cfg_idx_t           cfg_index,
	input  wire [REG_W-1:0]         cfg_data,
	// input channel
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire signed [IN_W-1:0]   speed_cmd,
	// output channel
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [OUT_W-1:0]        duty_forward,
	output logic [OUT_W-1:0]        duty_reverse
);

	// derived widths
	localparam int FW = $clog2(FULL_SCALE + 1);          // magnitude / quotient
	localparam int QW = FW;                               // quotient bits
	localparam int NW = 2 * FW;                           // product width
	localparam int SW = (FW + 1 > IN_W + 1) ? FW + 1 : IN_W + 1;
	localparam int EW = (FW > REG_W) ? FW : REG_W;
	localparam int DW = (FW + 1 > OUT_W) ? FW + 1 : OUT_W;
	localparam int NS = QW + 4;                           // stage count
	localparam int DV = 3;                                // first divider stage

	localparam logic signed [SW-1:0] FS_S = SW'(FULL_SCALE);
	localparam logic [EW-1:0]        FS_E = EW'(FULL_SCALE);
	localparam logic [FW-1:0]        FS_F = FW'(FULL_SCALE);
	localparam logic [FW-1:0]        FS_M1 = FW'(FULL_SCALE - 1);
	localparam logic [DW-1:0]        FS_D = DW'(FULL_SCALE);

	// configuration registers
	logic [REG_W-1:0] thr_q;
	logic [REG_W-1:0] start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			start_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q   <= cfg_data;
				REG_START:     start_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// effective threshold, start duty and remap constants
	logic [EW-1:0] thr_x;
	logic [EW-1:0] start_x;
	logic [FW-1:0] thr_eff;
	logic [FW-1:0] start_eff;
	logic [FW-1:0] den;
	logic [FW-1:0] span;

	always_comb begin
		thr_x     = EW'(thr_q);
		start_x   = EW'(start_q);
		thr_eff   = (thr_x >= FS_E) ? FS_M1 : thr_x[FW-1:0];
		start_eff = (start_x > FS_E) ? FS_F : start_x[FW-1:0];
		den       = FS_F - thr_eff;
		span      = FS_F - start_eff;
	end

	// stage valid bits and ready chain
	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;

	always_comb begin
		rdy[NS] = !out_stall;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// s1: saturate the command and take its magnitude
	logic signed [SW-1:0] spd_ext;
	logic signed [SW-1:0] spd_sat;
	logic signed [SW-1:0] spd_abs;
	logic                 neg_s1;
	logic [FW-1:0]        mag_s1;

	always_comb begin
		spd_ext = $signed({{(SW-IN_W){speed_cmd[IN_W-1]}}, speed_cmd});
		priority if (spd_ext > FS_S) begin
			spd_sat = FS_S;
		end else if (spd_ext < -FS_S) begin
			spd_sat = -FS_S;
		end else begin
			spd_sat = spd_ext;
		end
		spd_abs = speed_cmd[IN_W-1] ? -spd_sat : spd_sat;
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			neg_s1 <= speed_cmd[IN_W-1];
			mag_s1 <= spd_abs[FW-1:0];
		end
	end

	// s2: dead-band test and offset above threshold, zero inside the band
	logic          neg_s2;
	logic          run_s2;
	logic [FW-1:0] diff_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			neg_s2  <= neg_s1;
			run_s2  <= mag_s1 > thr_eff;
			diff_s2 <= (mag_s1 > thr_eff) ? mag_s1 - thr_eff : '0;
		end
	end

	// s3: scale the offset by the duty span
	logic          neg_s3;
	logic          run_s3;
	logic [NW-1:0] num_s3;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			neg_s3 <= neg_s2;
			run_s3 <= run_s2;
			num_s3 <= NW'(diff_s2) * NW'(span);
		end
	end

	// s4 onward: restoring divider, one quotient bit per stage, msb first
	logic          div_neg_s4 [QW];
	logic          div_run_s4 [QW];
	logic [NW-1:0] div_rem_s4 [QW];
	logic [QW-1:0] div_quo_s4 [QW];

	genvar j;
	generate
		for (j = 0; j < QW; j++) begin : g_div
			localparam int B = QW - 1 - j;

			logic          neg_in;
			logic          run_in;
			logic [NW-1:0] rem_in;
			logic [QW-1:0] quo_in;
			logic [NW-1:0] dsh;
			logic          take;

			if (j == 0) begin : g_first
				assign neg_in = neg_s3;
				assign run_in = run_s3;
				assign rem_in = num_s3;
				assign quo_in = '0;
			end else begin : g_next
				assign neg_in = div_neg_s4[j-1];
				assign run_in = div_run_s4[j-1];
				assign rem_in = div_rem_s4[j-1];
				assign quo_in = div_quo_s4[j-1];
			end

			assign dsh  = NW'(den) << B;
			assign take = rem_in >= dsh;

			always_ff @(posedge clk) begin
				if (rdy[DV+j]) begin
					div_neg_s4[j] <= neg_in;
					div_run_s4[j] <= run_in;
					div_rem_s4[j] <= take ? rem_in - dsh : rem_in;
					div_quo_s4[j] <= quo_in | (take ? QW'(1) << B : QW'(0));
				end
			end
		end
	endgenerate

	// final stage: add start duty, clamp, steer to one channel
	logic [DW-1:0]    duty_sum;
	logic [DW-1:0]    duty_clamp;
	logic [OUT_W-1:0] duty_out;
	logic [OUT_W-1:0] out_fwd_q;
	logic [OUT_W-1:0] out_rev_q;

	always_comb begin
		duty_sum   = DW'(start_eff) + DW'(div_quo_s4[QW-1]);
		duty_clamp = (duty_sum > FS_D) ? FS_D : duty_sum;
		duty_out   = div_run_s4[QW-1] ? duty_clamp[OUT_W-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			out_fwd_q <= div_neg_s4[QW-1] ? '0 : duty_out;
			out_rev_q <= div_neg_s4[QW-1] ? duty_out : '0;
		end
	end

	assign duty_forward = out_fwd_q;
	assign duty_reverse = out_rev_q;

`ifndef SYNTHESIS
	// only one bridge input is ever driven
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_forward == '0 || duty_reverse == '0))
		else $error("both bridge duties nonzero");

	// a duty never exceeds full scale when full scale fits the field
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (FULL_SCALE > ((1 << OUT_W) - 1)
			|| (duty_forward <= OUT_W'(FULL_SCALE) && duty_reverse <= OUT_W'(FULL_SCALE))))
		else $error("duty above full scale");

	// input is stalled only when every stage is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q))
		else $error("input stalled with an empty stage");

	// divider leaves a remainder below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NS-2] |-> (div_rem_s4[QW-1] < NW'(den)))
		else $error("divider remainder not reduced");
`endif

endmodule

`default_nettype wire
